// ===== hw/rtl/ttf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ttf_pkg;

  // field widths
  localparam int POS_W  = 32;          // position, Q16.16
  localparam int TEX_W  = 24;          // texture coordinate, Q8.16
  localparam int NRM_W  = 16;          // normal, Q2.14
  localparam int UNIT_W = 16;          // normalised output, Q2.14
  localparam int DP_W   = POS_W + 1;   // position delta
  localparam int DUV_W  = TEX_W + 1;   // uv delta

  localparam int ONE_Q14 = 16384;

  // job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // corner codes
  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  typedef struct packed {
    logic [1:0]              corner_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [TEX_W-1:0] tex_u;
    logic signed [TEX_W-1:0] tex_v;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;
  } in_word_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] tan_x;
    logic signed [UNIT_W-1:0] tan_y;
    logic signed [UNIT_W-1:0] tan_z;
    logic signed [UNIT_W-1:0] bitan_x;
    logic signed [UNIT_W-1:0] bitan_y;
    logic signed [UNIT_W-1:0] bitan_z;
    logic                     degenerate;
  } out_word_t;

  // one triangle, reduced to deltas and the corner-0 normal
  typedef struct packed {
    logic signed [DP_W-1:0]  dp1_x;
    logic signed [DP_W-1:0]  dp1_y;
    logic signed [DP_W-1:0]  dp1_z;
    logic signed [DP_W-1:0]  dp2_x;
    logic signed [DP_W-1:0]  dp2_y;
    logic signed [DP_W-1:0]  dp2_z;
    logic signed [DUV_W-1:0] du1;
    logic signed [DUV_W-1:0] dv1;
    logic signed [DUV_W-1:0] du2;
    logic signed [DUV_W-1:0] dv2;
    logic signed [NRM_W-1:0] n_x;
    logic signed [NRM_W-1:0] n_y;
    logic signed [NRM_W-1:0] n_z;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ttf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttf_front (
  input  logic              clk,
  input  logic              in_valid,
  output logic              in_stall,
  input  ttf_pkg::in_word_t in_word,
  input  logic              job_full,
  output logic              job_push,
  output ttf_pkg::job_t     job
);
  import ttf_pkg::*;

  // corner store, no reset
  logic signed [POS_W-1:0] pos0_r [3];
  logic signed [POS_W-1:0] pos1_r [3];
  logic signed [TEX_W-1:0] uv0_r  [2];
  logic signed [TEX_W-1:0] uv1_r  [2];
  logic signed [NRM_W-1:0] nrm_r  [3];
  logic                    accept;

  assign in_stall = job_full;
  assign accept   = in_valid && !in_stall;
  assign job_push = accept && (in_word.corner_index == CORNER_2);

  always_ff @(posedge clk) begin
    if (accept) begin
      case (in_word.corner_index)
        CORNER_0: begin
          pos0_r[0] <= in_word.pos_x;
          pos0_r[1] <= in_word.pos_y;
          pos0_r[2] <= in_word.pos_z;
          uv0_r[0]  <= in_word.tex_u;
          uv0_r[1]  <= in_word.tex_v;
          nrm_r[0]  <= in_word.norm_x;
          nrm_r[1]  <= in_word.norm_y;
          nrm_r[2]  <= in_word.norm_z;
        end
        CORNER_1: begin
          pos1_r[0] <= in_word.pos_x;
          pos1_r[1] <= in_word.pos_y;
          pos1_r[2] <= in_word.pos_z;
          uv1_r[0]  <= in_word.tex_u;
          uv1_r[1]  <= in_word.tex_v;
        end
        default: ;
      endcase
    end
  end

  // deltas against corner 0, exact
  always_comb begin
    job.dp1_x = DP_W'(pos1_r[0]) - DP_W'(pos0_r[0]);
    job.dp1_y = DP_W'(pos1_r[1]) - DP_W'(pos0_r[1]);
    job.dp1_z = DP_W'(pos1_r[2]) - DP_W'(pos0_r[2]);
    job.dp2_x = DP_W'(in_word.pos_x) - DP_W'(pos0_r[0]);
    job.dp2_y = DP_W'(in_word.pos_y) - DP_W'(pos0_r[1]);
    job.dp2_z = DP_W'(in_word.pos_z) - DP_W'(pos0_r[2]);
    job.du1   = DUV_W'(uv1_r[0]) - DUV_W'(uv0_r[0]);
    job.dv1   = DUV_W'(uv1_r[1]) - DUV_W'(uv0_r[1]);
    job.du2   = DUV_W'(in_word.tex_u) - DUV_W'(uv0_r[0]);
    job.dv2   = DUV_W'(in_word.tex_v) - DUV_W'(uv0_r[1]);
    job.n_x   = nrm_r[0];
    job.n_y   = nrm_r[1];
    job.n_z   = nrm_r[2];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ttf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ttf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          job_valid,
  output ttf_pkg::job_t pop_job
);
  import ttf_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [Q_CW-1:0] cnt_r;

  assign full      = (cnt_r == Q_CW'(Q_DEPTH));
  assign job_valid = (cnt_r != '0);
  assign pop_job   = mem_r[rp_r];
  assign wp_nxt    = (wp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_nxt    = (rp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_nxt;
      end
      if (pop) begin
        rp_r <= rp_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH)) else $error("job queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> job_valid) else $error("job popped from empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/ttf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  ttf_pkg::job_t      job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ttf_pkg::out_word_t out_word
);
  import ttf_pkg::*;

  localparam int PR_W  = DP_W + DUV_W;   // T/B and projection products
  localparam int MAG_W = PR_W - 1;       // magnitudes
  localparam int DET_W = 2 * DUV_W + 1;
  localparam int PS1_K = 24;             // prescale before projection
  localparam int PS2_K = 30;             // prescale before length
  localparam int U_W   = PS1_K + 1;
  localparam int DTP_W = U_W + NRM_W;
  localparam int DT_W  = DTP_W + 1;
  localparam int SQ_W  = 2 * PS2_K;
  localparam int X_W   = SQ_W + 2;
  localparam int R_W   = X_W + 1;
  localparam int LEN_W = PS2_K + 1;
  localparam int Q_SH  = 14;
  localparam int REM_W = LEN_W + Q_SH;
  localparam int QUO_W = Q_SH + 1;
  localparam int HP_W  = 2 * NRM_W;
  localparam int HD_W  = HP_W + NRM_W;

  typedef enum logic [4:0] {
    S_IDLE, S_DET1, S_DET2, S_TB1, S_TB2, S_PS1, S_DT1, S_DT2, S_PJ1, S_PJ2,
    S_PS2, S_SQ1, S_SQ2, S_ROOT, S_DIVI, S_DIV, S_STORE, S_H1, S_H2, S_H3,
    S_H4, S_OUT
  } state_t;

  state_t                   state_r;
  logic signed [DP_W-1:0]   dp1_r [3];
  logic signed [DP_W-1:0]   dp2_r [3];
  logic signed [DUV_W-1:0]  du1_r, dv1_r, du2_r, dv2_r;
  logic signed [NRM_W-1:0]  n_r [3];
  logic signed [2*DUV_W-1:0] pa_r, pb_r;
  logic signed [HP_W-1:0]   nsq_r [3];
  logic [HP_W-1:0]          nn_r;
  logic                     nn_zero_r, det_neg_r, fail_r, vsel_r;
  logic [1:0]               idx_r;
  logic signed [PR_W-1:0]   q_r [4];
  logic                     sgn_r [3];
  logic [MAG_W-1:0]         mag_r [3];
  logic                     bsg_r [3];
  logic [MAG_W-1:0]         bmag_r [3];
  logic signed [DTP_W-1:0]  dtp_r [3];
  logic signed [DT_W-1:0]   dt_r;
  logic signed [PR_W-1:0]   pu_r [3];
  logic signed [PR_W-1:0]   pn_r [3];
  logic [SQ_W-1:0]          sq_r [3];
  logic [X_W-1:0]           x_r;
  logic [R_W-1:0]           r_r;
  logic [4:0]               k_r;
  logic [REM_W-1:0]         rem_r [3];
  logic [REM_W-1:0]         dsh_r;
  logic [QUO_W-1:0]         quo_r [3];
  logic [3:0]               j_r;
  logic signed [UNIT_W-1:0] tn_r [3];
  logic signed [UNIT_W-1:0] bn_r [3];
  logic signed [HP_W-1:0]   hp_r [6];
  logic signed [HP_W-1:0]   c_r [3];
  logic signed [HD_W-1:0]   hd_r [3];
  logic                     out_valid_r;
  out_word_t                out_word_r;

  // combinational helpers
  logic signed [DET_W-1:0]  det_w;
  logic signed [U_W-1:0]    u_s [3];
  logic signed [PR_W-1:0]   t_d, t_dr, b_d, b_dr;
  logic                     t_sgn, b_sgn;
  logic [MAG_W-1:0]         t_mag, b_mag;
  logic signed [PR_W-1:0]   p_d [3];
  logic signed [PR_W-1:0]   p_dr [3];
  logic [2:0]               ps1_hi4, ps1_hi1, ps2_hi4, ps2_hi1;
  logic [X_W-1:0]           len2_w;
  logic [X_W+1:0]           sq_bit, sq_rb;
  logic                     sq_ge;
  logic [X_W-1:0]           x_nxt;
  logic [R_W-1:0]           r_nxt;
  logic [2:0]               dv_ge;
  logic [REM_W-1:0]         rem_nxt [3];
  logic signed [UNIT_W-1:0] o_v [3];
  logic signed [HD_W-1:0]   hsum;

  assign pop       = (state_r == S_IDLE) && job_valid;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign det_w = DET_W'(pa_r) - DET_W'(pb_r);

  // T and B component; sign(det) folded in by swapping the subtraction
  assign t_d   = q_r[0] - q_r[1];
  assign t_dr  = q_r[1] - q_r[0];
  assign b_d   = q_r[2] - q_r[3];
  assign b_dr  = q_r[3] - q_r[2];
  assign t_sgn = det_neg_r ? t_dr[PR_W-1] : t_d[PR_W-1];
  assign b_sgn = det_neg_r ? b_dr[PR_W-1] : b_d[PR_W-1];
  assign t_mag = t_d[PR_W-1] ? t_dr[MAG_W-1:0] : t_d[MAG_W-1:0];
  assign b_mag = b_d[PR_W-1] ? b_dr[MAG_W-1:0] : b_d[MAG_W-1:0];

  assign len2_w = X_W'(sq_r[0]) + X_W'(sq_r[1]) + X_W'(sq_r[2]);
  assign hsum   = hd_r[0] + hd_r[1] + hd_r[2];

  // one step of the bit-pair square root
  assign sq_bit = (X_W+2)'(1) << {k_r, 1'b0};
  assign sq_rb  = {1'b0, r_r} + sq_bit;
  assign sq_ge  = {2'b00, x_r} >= sq_rb;
  assign x_nxt  = sq_ge ? (x_r - sq_rb[X_W-1:0]) : x_r;
  assign r_nxt  = sq_ge ? ({1'b0, r_r[R_W-1:1]} + sq_bit[R_W-1:0])
                        : {1'b0, r_r[R_W-1:1]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_s[i] = sgn_r[i] ? -$signed({1'b0, mag_r[i][PS1_K-1:0]})
                        : $signed({1'b0, mag_r[i][PS1_K-1:0]});
      p_d[i]  = pu_r[i] - pn_r[i];
      p_dr[i] = pn_r[i] - pu_r[i];
      ps1_hi4[i] = |mag_r[i][MAG_W-1:PS1_K+3];
      ps1_hi1[i] = |mag_r[i][MAG_W-1:PS1_K];
      ps2_hi4[i] = |mag_r[i][MAG_W-1:PS2_K+3];
      ps2_hi1[i] = |mag_r[i][MAG_W-1:PS2_K];
      dv_ge[i]   = rem_r[i] >= dsh_r;
      rem_nxt[i] = dv_ge[i] ? (rem_r[i] - dsh_r) : rem_r[i];
      o_v[i] = sgn_r[i] ? -$signed({1'b0, quo_r[i]}) : $signed({1'b0, quo_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // the output state reloads the word itself
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            dp1_r[0] <= job.dp1_x;
            dp1_r[1] <= job.dp1_y;
            dp1_r[2] <= job.dp1_z;
            dp2_r[0] <= job.dp2_x;
            dp2_r[1] <= job.dp2_y;
            dp2_r[2] <= job.dp2_z;
            du1_r    <= job.du1;
            dv1_r    <= job.dv1;
            du2_r    <= job.du2;
            dv2_r    <= job.dv2;
            n_r[0]   <= job.n_x;
            n_r[1]   <= job.n_y;
            n_r[2]   <= job.n_z;
            fail_r   <= 1'b0;
            state_r  <= S_DET1;
          end
        end
        S_DET1: begin
          pa_r <= du1_r * dv2_r;
          pb_r <= dv1_r * du2_r;
          for (int i = 0; i < 3; i++) begin
            nsq_r[i] <= n_r[i] * n_r[i];
          end
          state_r <= S_DET2;
        end
        S_DET2: begin
          nn_r      <= unsigned'(nsq_r[0]) + unsigned'(nsq_r[1]) + unsigned'(nsq_r[2]);
          nn_zero_r <= (nsq_r[0] == '0) && (nsq_r[1] == '0) && (nsq_r[2] == '0);
          det_neg_r <= det_w[DET_W-1];
          idx_r     <= '0;
          if (det_w == '0) begin
            fail_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_TB1;
          end
        end
        S_TB1: begin
          q_r[0]  <= dp1_r[idx_r] * dv2_r;
          q_r[1]  <= dv1_r * dp2_r[idx_r];
          q_r[2]  <= du1_r * dp2_r[idx_r];
          q_r[3]  <= dp1_r[idx_r] * du2_r;
          state_r <= S_TB2;
        end
        S_TB2: begin
          sgn_r[idx_r]  <= t_sgn;
          mag_r[idx_r]  <= t_mag;
          bsg_r[idx_r]  <= b_sgn;
          bmag_r[idx_r] <= b_mag;
          vsel_r        <= 1'b0;
          if (idx_r == 2'd2) begin
            state_r <= S_PS1;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_TB1;
          end
        end
        S_PS1: begin
          if (|ps1_hi4) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 4;
          end else if (|ps1_hi1) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else begin
            state_r <= nn_zero_r ? S_PS2 : S_DT1;
          end
        end
        S_DT1: begin
          for (int i = 0; i < 3; i++) begin
            dtp_r[i] <= u_s[i] * n_r[i];
          end
          state_r <= S_DT2;
        end
        S_DT2: begin
          dt_r    <= DT_W'(dtp_r[0]) + DT_W'(dtp_r[1]) + DT_W'(dtp_r[2]);
          state_r <= S_PJ1;
        end
        S_PJ1: begin
          for (int i = 0; i < 3; i++) begin
            pu_r[i] <= u_s[i] * $signed({1'b0, nn_r});
            pn_r[i] <= n_r[i] * dt_r;
          end
          state_r <= S_PJ2;
        end
        S_PJ2: begin
          for (int i = 0; i < 3; i++) begin
            sgn_r[i] <= p_d[i][PR_W-1];
            mag_r[i] <= p_d[i][PR_W-1] ? p_dr[i][MAG_W-1:0] : p_d[i][MAG_W-1:0];
          end
          state_r <= S_PS2;
        end
        S_PS2: begin
          if (|ps2_hi4) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 4;
          end else if (|ps2_hi1) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else begin
            state_r <= S_SQ1;
          end
        end
        S_SQ1: begin
          for (int i = 0; i < 3; i++) begin
            sq_r[i] <= mag_r[i][PS2_K-1:0] * mag_r[i][PS2_K-1:0];
          end
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          x_r <= len2_w;
          r_r <= '0;
          k_r <= 5'd31;
          if (len2_w == '0) begin
            fail_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          x_r <= x_nxt;
          r_r <= r_nxt;
          if (k_r == '0) begin
            state_r <= S_DIVI;
          end else begin
            k_r <= k_r - 1'b1;
          end
        end
        S_DIVI: begin
          // numerator |u|*2^14 + len/2, divisor len aligned to the top quotient bit
          for (int i = 0; i < 3; i++) begin
            rem_r[i] <= REM_W'({mag_r[i][PS2_K-1:0], {Q_SH{1'b0}}})
                        + REM_W'(r_r[LEN_W-1:1]);
            quo_r[i] <= '0;
          end
          dsh_r   <= {r_r[LEN_W-1:0], {Q_SH{1'b0}}};
          j_r     <= 4'(QUO_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < 3; i++) begin
            rem_r[i] <= rem_nxt[i];
            quo_r[i] <= {quo_r[i][QUO_W-2:0], dv_ge[i]};
          end
          dsh_r <= dsh_r >> 1;
          if (j_r == '0) begin
            state_r <= S_STORE;
          end else begin
            j_r <= j_r - 1'b1;
          end
        end
        S_STORE: begin
          if (!vsel_r) begin
            for (int i = 0; i < 3; i++) begin
              tn_r[i]  <= o_v[i];
              sgn_r[i] <= bsg_r[i];
              mag_r[i] <= bmag_r[i];
            end
            vsel_r  <= 1'b1;
            state_r <= S_PS1;
          end else begin
            for (int i = 0; i < 3; i++) bn_r[i] <= o_v[i];
            state_r <= S_H1;
          end
        end
        S_H1: begin
          hp_r[0] <= n_r[1] * tn_r[2];
          hp_r[1] <= n_r[2] * tn_r[1];
          hp_r[2] <= n_r[2] * tn_r[0];
          hp_r[3] <= n_r[0] * tn_r[2];
          hp_r[4] <= n_r[0] * tn_r[1];
          hp_r[5] <= n_r[1] * tn_r[0];
          state_r <= S_H2;
        end
        S_H2: begin
          c_r[0]  <= hp_r[0] - hp_r[1];
          c_r[1]  <= hp_r[2] - hp_r[3];
          c_r[2]  <= hp_r[4] - hp_r[5];
          state_r <= S_H3;
        end
        S_H3: begin
          for (int i = 0; i < 3; i++) begin
            hd_r[i] <= c_r[i] * bn_r[i];
          end
          state_r <= S_H4;
        end
        S_H4: begin
          // left-handed frame: flip T
          if (hsum[HD_W-1]) begin
            for (int i = 0; i < 3; i++) tn_r[i] <= -tn_r[i];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r           <= 1'b1;
            out_word_r.tan_x      <= fail_r ? '0 : tn_r[0];
            out_word_r.tan_y      <= fail_r ? '0 : tn_r[1];
            out_word_r.tan_z      <= fail_r ? '0 : tn_r[2];
            out_word_r.bitan_x    <= fail_r ? '0 : bn_r[0];
            out_word_r.bitan_y    <= fail_r ? '0 : bn_r[1];
            out_word_r.bitan_z    <= fail_r ? '0 : bn_r[2];
            out_word_r.degenerate <= fail_r;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE) |-> (quo_r[0] <= QUO_W'(ONE_Q14) &&
                              quo_r[1] <= QUO_W'(ONE_Q14) &&
                              quo_r[2] <= QUO_W'(ONE_Q14)))
    else $error("normalised component above one");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word raised outside output state");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.degenerate) |->
      (out_word_r.tan_x == '0 && out_word_r.tan_y == '0 && out_word_r.tan_z == '0 &&
       out_word_r.bitan_x == '0 && out_word_r.bitan_y == '0 &&
       out_word_r.bitan_z == '0))
    else $error("degenerate result with non-zero vectors");

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_tangent_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-triangle tangent frame. Feed a triangle as three words, corners 0, 1
// and 2; corner 2 yields one result word with unit tangent and bitangent in
// Q2.14, orthogonalised against the corner-0 normal, tangent flipped for a
// left-handed frame, degenerate set (vectors zero) on a zero UV determinant
// or a zero projected vector. Corner index 3 is dropped. Any word is taken
// while the two-entry job queue has room; a full queue stalls every corner,
// so up to two triangles can wait behind the one being worked on. The back
// end works one triangle at a time: per vector two prescale loops, the
// projection, a 32-step square root and a 15-step divider (three lanes in
// parallel), plus the pop, determinant, T/B build, handedness and output
// load. A zero determinant ends straight after the determinant, a vanishing
// projected vector before its square root. A finished word sits in the
// output register; while it is stalled the back end holds its next result,
// and the queue then fills and stalls the front.

module triangle_tangent_frame (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ttf_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ttf_pkg::out_word_t out_word
);
  import ttf_pkg::*;

  job_t front_job, queue_job;
  logic job_push, job_full, job_valid, job_pop;

  // front: corner store and delta forming
  ttf_front u_front (
    .clk      (clk),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .job_full (job_full),
    .job_push (job_push),
    .job      (front_job)
  );

  // decouples the front from the long back-end sequence
  ttf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (front_job),
    .full      (job_full),
    .pop       (job_pop),
    .job_valid (job_valid),
    .pop_job   (queue_job)
  );

  // back: solve, project, normalise, handedness, output register
  ttf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (queue_job),
    .pop       (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== tb/triangle_tangent_frame_tb.sv =====
`timescale 1ns / 1ps

module triangle_tangent_frame_tb;
  import ttf_pkg::*;

  typedef longint vec3_t[3];

  localparam int CLK_HALF   = 6;       // 12 ns period
  localparam int WDOG_LIMIT = 4000;    // cycles with no word moving on either side
  localparam int HOLD_LEN   = 700;     // long receiver hold-off, cycles
  localparam int HOLD_AT    = 1000;    // input words accepted before the hold-off
  localparam int PHASE_LEN  = 450;     // input words per idling phase

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  triangle_tangent_frame dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // words waiting to be sent, and frames the block owes us
  in_word_t  corner_q[$];
  out_word_t frame_q[$];

  // predictor's copy of the corner store
  longint held_pos[6];
  longint held_tex[4];
  longint held_nrm[3];

  int n_in, n_out, n_degen, n_err, quiet;
  int send_idle, recv_idle;
  int hold_cnt;
  bit hold_done;
  bit started;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact integer tangent frame
  // ---------------------------------------------------------------------------
  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // common right shift of magnitudes until all lie below 2^k
  function automatic vec3_t shrink(vec3_t v, int k);
    longint unsigned mx, m;
    int s;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = mag(v[i]);
      if (m > mx) mx = m;
    end
    while ((mx >> s) >= (64'd1 << k)) s++;
    for (int i = 0; i < 3; i++) begin
      m = mag(v[i]) >> s;
      v[i] = v[i] < 0 ? -longint'(m) : longint'(m);
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // take v off the normal and scale to Q2.14; 0 when nothing is left
  function automatic bit ortho_q14(vec3_t v, vec3_t n, output vec3_t o);
    vec3_t u;
    longint nn, dt;
    longint unsigned len2, len, q;
    u = shrink(v, 24);
    nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    if (nn != 0) begin
      dt = u[0] * n[0] + u[1] * n[1] + u[2] * n[2];
      for (int i = 0; i < 3; i++) u[i] = u[i] * nn - n[i] * dt;
    end
    u = shrink(u, 30);
    len2 = 0;
    for (int i = 0; i < 3; i++) len2 += mag(u[i]) * mag(u[i]);
    o = '{0, 0, 0};
    if (len2 == 0) return 1'b0;
    len = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = (mag(u[i]) * ONE_Q14 + len / 2) / len;
      o[i] = u[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // updates the corner store; returns 1 with the frame on corner 2
  function automatic bit frame_for(in_word_t w, output out_word_t f);
    vec3_t p, dp1, dp2, t, b, tn, bn, c;
    longint tu, tv, du1, dv1, du2, dv2, det;
    bit ok;
    p[0] = w.pos_x;
    p[1] = w.pos_y;
    p[2] = w.pos_z;
    tu = w.tex_u;
    tv = w.tex_v;
    f = '0;
    if (w.corner_index == CORNER_0 || w.corner_index == CORNER_1) begin
      for (int i = 0; i < 3; i++) held_pos[w.corner_index * 3 + i] = p[i];
      held_tex[w.corner_index * 2]     = tu;
      held_tex[w.corner_index * 2 + 1] = tv;
      if (w.corner_index == CORNER_0) begin
        held_nrm[0] = w.norm_x;
        held_nrm[1] = w.norm_y;
        held_nrm[2] = w.norm_z;
      end
      return 1'b0;
    end
    if (w.corner_index != CORNER_2) return 1'b0;   // index 3: dropped

    for (int i = 0; i < 3; i++) begin
      dp1[i] = held_pos[3 + i] - held_pos[i];
      dp2[i] = p[i] - held_pos[i];
    end
    du1 = held_tex[2] - held_tex[0];
    dv1 = held_tex[3] - held_tex[1];
    du2 = tu - held_tex[0];
    dv2 = tv - held_tex[1];
    det = du1 * dv2 - dv1 * du2;
    ok  = det != 0;
    tn  = '{0, 0, 0};
    bn  = '{0, 0, 0};
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        t[i] = dp1[i] * dv2 - dv1 * dp2[i];
        b[i] = du1 * dp2[i] - dp1[i] * du2;
        if (det < 0) begin
          t[i] = -t[i];
          b[i] = -b[i];
        end
      end
      ok = ortho_q14(t, held_nrm, tn);
      if (ok) ok = ortho_q14(b, held_nrm, bn);
    end
    if (ok) begin
      // left-handed frame: flip the tangent
      c[0] = held_nrm[1] * tn[2] - held_nrm[2] * tn[1];
      c[1] = held_nrm[2] * tn[0] - held_nrm[0] * tn[2];
      c[2] = held_nrm[0] * tn[1] - held_nrm[1] * tn[0];
      if (c[0] * bn[0] + c[1] * bn[1] + c[2] * bn[2] < 0)
        for (int i = 0; i < 3; i++) tn[i] = -tn[i];
    end else begin
      tn = '{0, 0, 0};
      bn = '{0, 0, 0};
    end
    f.tan_x      = UNIT_W'(tn[0]);
    f.tan_y      = UNIT_W'(tn[1]);
    f.tan_z      = UNIT_W'(tn[2]);
    f.bitan_x    = UNIT_W'(bn[0]);
    f.bitan_y    = UNIT_W'(bn[1]);
    f.bitan_z    = UNIT_W'(bn[2]);
    f.degenerate = ~ok;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic in_word_t corner_word(logic [1:0] ci, int px, int py, int pz,
                                           int u, int v, int nx, int ny, int nz);
    in_word_t w;
    w.corner_index = ci;
    w.pos_x  = px;
    w.pos_y  = py;
    w.pos_z  = pz;
    w.tex_u  = TEX_W'(u);
    w.tex_v  = TEX_W'(v);
    w.norm_x = NRM_W'(nx);
    w.norm_y = NRM_W'(ny);
    w.norm_z = NRM_W'(nz);
    return w;
  endfunction

  function automatic int rnd_norm();
    return int'($urandom_range(2 * ONE_Q14)) - ONE_Q14;
  endfunction

  function automatic int rnd_tex();
    return int'({{8{1'b0}}, $urandom} << 8) >>> 8;   // 24-bit signed
  endfunction

  // one random corner; near a base point most of the time
  function automatic in_word_t rnd_corner(logic [1:0] ci, int base, int nx, int ny, int nz,
                                          int ubase, int vbase);
    int sz;
    sz = $urandom_range(3);
    if (sz == 0)
      return corner_word(ci, $urandom, $urandom, $urandom, rnd_tex(), rnd_tex(),
                         nx, ny, nz);
    return corner_word(ci,
                       base + int'($urandom_range(1 << 20)) - (1 << 19),
                       base + int'($urandom_range(1 << 20)) - (1 << 19),
                       base + int'($urandom_range(1 << 20)) - (1 << 19),
                       ubase + int'($urandom_range(1 << 16)) - (1 << 15),
                       vbase + int'($urandom_range(1 << 16)) - (1 << 15),
                       nx, ny, nz);
  endfunction

  task automatic add_tri(in_word_t c0, in_word_t c1, in_word_t c2);
    corner_q.push_back(c0);
    corner_q.push_back(c1);
    corner_q.push_back(c2);
  endtask

  task automatic build_stimulus();
    int base, ub, vb, nx, ny, nz, kind;
    in_word_t c0, c1, c2;
    localparam int ONE = 65536;
    // unit square in xy, uv matching: frame along x / y
    add_tri(corner_word(CORNER_0, 0, 0, 0, 0, 0, 0, 0, ONE_Q14),
            corner_word(CORNER_1, ONE, 0, 0, ONE, 0, 0, 0, 0),
            corner_word(CORNER_2, 0, ONE, 0, 0, ONE, 0, 0, 0));
    // normal facing away: left-handed, tangent flipped
    add_tri(corner_word(CORNER_0, 0, 0, 0, 0, 0, 0, 0, -ONE_Q14),
            corner_word(CORNER_1, ONE, 0, 0, ONE, 0, 0, 0, 0),
            corner_word(CORNER_2, 0, ONE, 0, 0, ONE, 0, 0, 0));
    // tangent parallel to the normal: projected vector vanishes
    add_tri(corner_word(CORNER_0, 0, 0, 0, 0, 0, ONE_Q14, 0, 0),
            corner_word(CORNER_1, ONE, 0, 0, ONE, 0, 0, 0, 0),
            corner_word(CORNER_2, 0, ONE, 0, 0, ONE, 0, 0, 0));
    // zero determinant: all uv equal
    add_tri(corner_word(CORNER_0, 5, 7, 9, 1234, 1234, 0, ONE_Q14, 0),
            corner_word(CORNER_1, ONE, 3, 0, 1234, 1234, 0, 0, 0),
            corner_word(CORNER_2, 0, ONE, 8, 1234, 1234, 0, 0, 0));
    // zero normal: no projection, no flip
    add_tri(corner_word(CORNER_0, 0, 0, 0, 0, 0, 0, 0, 0),
            corner_word(CORNER_1, ONE, 0, ONE, ONE, 0, 0, 0, 0),
            corner_word(CORNER_2, 0, -ONE, 0, 0, -ONE, 0, 0, 0));
    // field extremes, positions and uv at both rails
    add_tri(corner_word(CORNER_0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                        -8388608, 8388607, -ONE_Q14, ONE_Q14, -ONE_Q14),
            corner_word(CORNER_1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        8388607, -8388608, 0, 0, 0),
            corner_word(CORNER_2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                        8388607, 8388607, 0, 0, 0));
    // index 3 ignored, corner 1 repeated, then corner 2 twice on the same store
    corner_q.push_back(corner_word(2'd3, -1, -1, -1, -1, -1, -1, -1, -1));
    corner_q.push_back(corner_word(CORNER_1, 3 * ONE, 0, 0, 0, ONE, 0, 0, 0));
    corner_q.push_back(corner_word(CORNER_1, 0, 2 * ONE, 0, 2 * ONE, 0, 0, 0, 0));
    corner_q.push_back(corner_word(CORNER_2, 0, 0, ONE, ONE, ONE, 0, 0, 0));
    corner_q.push_back(corner_word(CORNER_2, ONE, ONE, ONE, -ONE, ONE, 0, 0, 0));

    while (corner_q.size() < 1800) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        // noise: a lone word with any index, full-range content
        corner_q.push_back(corner_word(2'($urandom), $urandom, $urandom, $urandom,
                                       rnd_tex(), rnd_tex(), rnd_norm(), rnd_norm(),
                                       rnd_norm()));
      end else begin
        base = $urandom;
        ub = rnd_tex() >>> 2;
        vb = rnd_tex() >>> 2;
        case ($urandom_range(7))
          0: begin nx = 0; ny = 0; nz = 0; end
          1: begin nx = ONE_Q14; ny = 0; nz = 0; end
          default: begin nx = rnd_norm(); ny = rnd_norm(); nz = rnd_norm(); end
        endcase
        c0 = rnd_corner(CORNER_0, base, nx, ny, nz, ub, vb);
        c1 = rnd_corner(CORNER_1, base, rnd_norm(), rnd_norm(), rnd_norm(), ub, vb);
        c2 = rnd_corner(CORNER_2, base, rnd_norm(), rnd_norm(), rnd_norm(), ub, vb);
        if (kind < 16) begin
          // uv collinear: zero determinant
          c1.tex_u = c0.tex_u;
          c1.tex_v = c0.tex_v;
        end
        if (kind < 22 && kind >= 16) begin
          // broken sequence: corner 1 left out, old one reused
          corner_q.push_back(c0);
          corner_q.push_back(c2);
        end else begin
          add_tri(c0, c1, c2);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers words, records each accepted one in the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t f;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_word  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        n_in <= n_in + 1;
        if (frame_for(in_word, f)) frame_q.push_back(f);
      end
      // new word only once the current one is gone
      if (!in_valid || !in_stall) begin
        if (started && corner_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_word  <= corner_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // idling phases follow progress on the input side
  always_comb begin
    case ((n_in / PHASE_LEN) % 4)
      0:       begin send_idle = 0;  recv_idle = 0;  end
      1:       begin send_idle = 45; recv_idle = 0;  end
      2:       begin send_idle = 0;  recv_idle = 45; end
      default: begin send_idle = 6;  recv_idle = 6;  end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: receiver stall, result checking
  // ---------------------------------------------------------------------------
  task automatic report(string what, int got, int want);
    $display("mismatch on frame %0d: %s got %0d want %0d", n_out, what, got, want);
    n_err++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out <= n_out + 1;
        if (frame_q.size() == 0) begin
          report("frames pending", 1, 0);
        end else begin
          want = frame_q.pop_front();
          if (out_word.degenerate) n_degen <= n_degen + 1;
          if (out_word.tan_x != want.tan_x)   report("tan_x", out_word.tan_x, want.tan_x);
          if (out_word.tan_y != want.tan_y)   report("tan_y", out_word.tan_y, want.tan_y);
          if (out_word.tan_z != want.tan_z)   report("tan_z", out_word.tan_z, want.tan_z);
          if (out_word.bitan_x != want.bitan_x)
            report("bitan_x", out_word.bitan_x, want.bitan_x);
          if (out_word.bitan_y != want.bitan_y)
            report("bitan_y", out_word.bitan_y, want.bitan_y);
          if (out_word.bitan_z != want.bitan_z)
            report("bitan_z", out_word.bitan_z, want.bitan_z);
          if (out_word.degenerate != want.degenerate)
            report("degenerate", out_word.degenerate, want.degenerate);
        end
      end
      // one long hold-off while the sender keeps pushing, so the job queue fills
      if (hold_cnt != 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && n_in >= HOLD_AT) begin
        hold_cnt  <= HOLD_LEN;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(99) < recv_idle;
      end
    end
  end

  // watchdog: cycles in which no word moves on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", quiet);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    started   = 1'b0;
    n_in = 0;
    n_out = 0;
    n_degen = 0;
    n_err = 0;
    quiet = 0;
    for (int i = 0; i < 6; i++) held_pos[i] = 0;
    for (int i = 0; i < 4; i++) held_tex[i] = 0;
    for (int i = 0; i < 3; i++) held_nrm[i] = 0;
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    started <= 1'b1;

    // everything sent, everything back, then a back-end's worth of settling
    while (corner_q.size() != 0 || in_valid || frame_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("%0d corner words in, %0d frames checked (%0d degenerate),", n_in, n_out,
             n_degen);
    $display("four idling phases and one long output hold-off; %0d mismatches", n_err);
    if (n_err == 0 && frame_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ttf_pkg.sv
hw/rtl/ttf_front.sv
hw/rtl/ttf_queue.sv
hw/rtl/ttf_back.sv
hw/rtl/triangle_tangent_frame.sv
tb/triangle_tangent_frame_tb.sv
